// ----- design/m6502_pkg.sv -----
// Package for the 6502 bus-cycle core: sequence steps, operation and addressing-mode
// codes, flag positions, the cycle-count table and the opcode decoder.
// No dependencies.
package m6502_pkg;

	localparam int ADDRESS_BITS = 16;

	typedef logic [3:0] step_t;
	localparam step_t ST_RESET   = 4'd0;
	localparam step_t ST_VEC_LO  = 4'd1;
	localparam step_t ST_VEC_HI  = 4'd2;
	localparam step_t ST_OPCODE  = 4'd3;
	localparam step_t ST_OPER1   = 4'd4;
	localparam step_t ST_OPER2   = 4'd5;
	localparam step_t ST_PTR_LO  = 4'd6;
	localparam step_t ST_PTR_HI  = 4'd7;
	localparam step_t ST_DATA    = 4'd8;
	localparam step_t ST_WDONE   = 4'd9;
	localparam step_t ST_PUSH_HI = 4'd10;
	localparam step_t ST_PUSH_LO = 4'd11;
	localparam step_t ST_PUSH_P  = 4'd12;
	localparam step_t ST_PULL1   = 4'd13;
	localparam step_t ST_PULL2   = 4'd14;
	localparam step_t ST_PULL3   = 4'd15;

	typedef enum logic [3:0] {
		M_IMP, M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABX, M_ABY, M_IDX, M_IDY, M_REL, M_IND
	} mode_t;

	typedef enum logic [5:0] {
		O_NOP, O_ORA, O_AND, O_EOR, O_ADC, O_STA, O_LDA, O_CMP, O_SBC,
		O_ASL, O_ROL, O_LSR, O_ROR, O_STX, O_LDX, O_DEC, O_INC,
		O_BIT, O_JMP, O_STY, O_LDY, O_CPY, O_CPX, O_BR, O_BRK, O_JSR, O_RTI, O_RTS,
		O_PHP, O_PLP, O_PHA, O_PLA, O_DEY, O_TAY, O_INY, O_INX, O_CLC, O_SEC,
		O_CLI, O_SEI, O_TYA, O_CLV, O_CLD, O_SED, O_TXA, O_TAX, O_DEX, O_TXS, O_TSX
	} op_t;

	typedef struct packed {
		op_t   op;
		mode_t mode;
	} dec_t;

	localparam int FL_C = 0;
	localparam int FL_Z = 1;
	localparam int FL_I = 2;
	localparam int FL_D = 3;
	localparam int FL_V = 6;
	localparam int FL_N = 7;

	localparam logic [15:0] VEC_RESET = 16'hFFFC;
	localparam logic [15:0] VEC_IRQ   = 16'hFFFE;
	localparam logic [7:0]  SP_RESET  = 8'hFF;
	localparam logic [7:0]  P_RESET   = 8'h20;
	localparam logic [7:0]  P_PUSH    = 8'h30;
	localparam logic [7:0]  P_PULL    = 8'hCF;
	localparam logic [7:0]  STACK_PAGE = 8'h01;

	function automatic logic [3:0] cyc_lookup(input logic [7:0] o);
		int rows [0:7][0:31];
		rows[0] = '{7,6,0,8,3,3,5,5,3,2,2,2,4,4,6,6,2,5,0,8,4,4,6,6,2,4,2,7,4,4,7,7};
		rows[1] = '{6,6,0,8,3,3,5,5,4,2,2,2,4,4,6,6,2,5,0,8,4,4,6,6,2,4,2,7,4,4,7,7};
		rows[2] = '{6,6,0,8,3,3,5,5,3,2,2,2,3,4,6,6,2,5,0,8,4,4,6,6,2,4,2,7,4,4,7,7};
		rows[3] = '{6,6,0,8,3,3,5,5,4,2,2,2,5,4,6,6,2,5,0,8,4,4,6,6,2,4,2,7,4,4,7,7};
		rows[4] = '{1,6,2,6,3,3,3,3,2,2,2,2,4,4,4,4,2,6,0,6,4,4,4,4,2,5,2,5,5,5,5,5};
		rows[5] = '{2,6,2,6,3,3,3,3,2,2,2,2,4,4,4,4,2,5,0,5,4,4,4,4,2,4,2,4,4,4,4,4};
		rows[6] = '{2,6,2,8,3,3,5,5,2,2,2,2,4,4,6,6,2,5,0,8,4,4,6,6,2,4,2,7,4,4,7,7};
		rows[7] = '{2,6,2,8,3,3,5,5,2,2,2,2,4,4,6,6,2,5,0,8,4,4,6,6,2,4,2,7,4,4,7,7};
		return 4'(rows[o[7:5]][o[4:0]]);
	endfunction

	function automatic dec_t decode(input logic [7:0] o);
		dec_t r;
		logic [2:0] aaa;
		logic [2:0] bbb;
		logic [1:0] cc;
		aaa = o[7:5];
		bbb = o[4:2];
		cc = o[1:0];
		r.op = O_NOP;
		r.mode = M_IMP;
		if (cc == 2'd1) begin
			if (o != 8'h89) begin
				case (aaa)
					3'd0: r.op = O_ORA;
					3'd1: r.op = O_AND;
					3'd2: r.op = O_EOR;
					3'd3: r.op = O_ADC;
					3'd4: r.op = O_STA;
					3'd5: r.op = O_LDA;
					3'd6: r.op = O_CMP;
					default: r.op = O_SBC;
				endcase
				case (bbb)
					3'd0: r.mode = M_IDX;
					3'd1: r.mode = M_ZP;
					3'd2: r.mode = M_IMM;
					3'd3: r.mode = M_ABS;
					3'd4: r.mode = M_IDY;
					3'd5: r.mode = M_ZPX;
					3'd6: r.mode = M_ABY;
					default: r.mode = M_ABX;
				endcase
			end
		end else if (cc == 2'd2) begin
			case (aaa)
				3'd0: r.op = O_ASL;
				3'd1: r.op = O_ROL;
				3'd2: r.op = O_LSR;
				3'd3: r.op = O_ROR;
				3'd4: r.op = O_STX;
				3'd5: r.op = O_LDX;
				3'd6: r.op = O_DEC;
				default: r.op = O_INC;
			endcase
			case (bbb)
				3'd0: begin
					if (o == 8'hA2) r.mode = M_IMM;
					else r.op = O_NOP;
				end
				3'd1: r.mode = M_ZP;
				3'd2: begin
					if (aaa >= 3'd4) begin
						r.op = (o == 8'h8A) ? O_TXA : (o == 8'hAA) ? O_TAX :
							(o == 8'hCA) ? O_DEX : O_NOP;
					end
				end
				3'd3: r.mode = M_ABS;
				3'd5: r.mode = (aaa == 3'd4 || aaa == 3'd5) ? M_ZPY : M_ZPX;
				3'd6: r.op = (o == 8'h9A) ? O_TXS : (o == 8'hBA) ? O_TSX : O_NOP;
				3'd7: begin
					if (aaa == 3'd4) r.op = O_NOP;
					else r.mode = (aaa == 3'd5) ? M_ABY : M_ABX;
				end
				default: r.op = O_NOP;
			endcase
		end else if (cc == 2'd0) begin
			if (o[4:0] == 5'h10) begin
				r.op = O_BR;
				r.mode = M_REL;
			end else if (o[3:0] == 4'h8) begin
				case (o[7:4])
					4'h0: r.op = O_PHP;
					4'h1: r.op = O_CLC;
					4'h2: r.op = O_PLP;
					4'h3: r.op = O_SEC;
					4'h4: r.op = O_PHA;
					4'h5: r.op = O_CLI;
					4'h6: r.op = O_PLA;
					4'h7: r.op = O_SEI;
					4'h8: r.op = O_DEY;
					4'h9: r.op = O_TYA;
					4'hA: r.op = O_TAY;
					4'hB: r.op = O_CLV;
					4'hC: r.op = O_INY;
					4'hD: r.op = O_CLD;
					4'hE: r.op = O_INX;
					default: r.op = O_SED;
				endcase
			end else begin
				case (o)
					8'h00: r.op = O_BRK;
					8'h20: begin r.op = O_JSR; r.mode = M_ABS; end
					8'h40: r.op = O_RTI;
					8'h60: r.op = O_RTS;
					8'h24: begin r.op = O_BIT; r.mode = M_ZP; end
					8'h2C: begin r.op = O_BIT; r.mode = M_ABS; end
					8'h4C: begin r.op = O_JMP; r.mode = M_ABS; end
					8'h6C: begin r.op = O_JMP; r.mode = M_IND; end
					8'h84: begin r.op = O_STY; r.mode = M_ZP; end
					8'h8C: begin r.op = O_STY; r.mode = M_ABS; end
					8'h94: begin r.op = O_STY; r.mode = M_ZPX; end
					8'hA0: begin r.op = O_LDY; r.mode = M_IMM; end
					8'hA4: begin r.op = O_LDY; r.mode = M_ZP; end
					8'hAC: begin r.op = O_LDY; r.mode = M_ABS; end
					8'hB4: begin r.op = O_LDY; r.mode = M_ZPX; end
					8'hBC: begin r.op = O_LDY; r.mode = M_ABX; end
					8'hC0: begin r.op = O_CPY; r.mode = M_IMM; end
					8'hC4: begin r.op = O_CPY; r.mode = M_ZP; end
					8'hCC: begin r.op = O_CPY; r.mode = M_ABS; end
					8'hE0: begin r.op = O_CPX; r.mode = M_IMM; end
					8'hE4: begin r.op = O_CPX; r.mode = M_ZP; end
					8'hEC: begin r.op = O_CPX; r.mode = M_ABS; end
					default: r.op = O_NOP;
				endcase
			end
		end
		return r;
	endfunction

endpackage

// ----- design/m6502_alu.sv -----
// ALU of the 6502 bus-cycle core: load, logic, add/subtract, compare, BIT
// and read-modify-write operations with their flag updates. Uses m6502_pkg.
module m6502_alu import m6502_pkg::*; (
	input  op_t        op,
	input  logic [7:0] value,
	input  logic [7:0] acc,
	input  logic [7:0] xr,
	input  logic [7:0] yr,
	input  logic [7:0] p_in,
	output logic [7:0] result,
	output logic [7:0] p_out
);
	logic [8:0] sum;
	logic [7:0] addend;
	logic [7:0] cmp_reg;
	logic [8:0] diff;

	always_comb begin
		addend = (op == O_SBC) ? ~value : value;
		sum = {1'b0, acc} + {1'b0, addend} + {8'd0, p_in[FL_C]};
		cmp_reg = (op == O_CPX) ? xr : (op == O_CPY) ? yr : acc;
		diff = {1'b0, cmp_reg} - {1'b0, value};
		result = value;
		p_out = p_in;
		case (op)
			O_ORA: result = acc | value;
			O_AND: result = acc & value;
			O_EOR: result = acc ^ value;
			O_ADC, O_SBC: begin
				result = sum[7:0];
				p_out[FL_C] = sum[8];
				p_out[FL_V] = ~(acc[7] ^ addend[7]) & (acc[7] ^ sum[7]);
			end
			O_CMP, O_CPX, O_CPY: begin
				result = diff[7:0];
				p_out[FL_C] = ~diff[8];
			end
			O_ASL: begin result = {value[6:0], 1'b0}; p_out[FL_C] = value[7]; end
			O_ROL: begin result = {value[6:0], p_in[FL_C]}; p_out[FL_C] = value[7]; end
			O_LSR: begin result = {1'b0, value[7:1]}; p_out[FL_C] = value[0]; end
			O_ROR: begin result = {p_in[FL_C], value[7:1]}; p_out[FL_C] = value[0]; end
			O_INC: result = value + 8'd1;
			O_DEC: result = value - 8'd1;
			default: result = value;
		endcase
		if (op == O_BIT) begin
			p_out[FL_N] = value[7];
			p_out[FL_V] = value[6];
			p_out[FL_Z] = (value & acc) == 8'd0;
		end else begin
			p_out[FL_N] = result[7];
			p_out[FL_Z] = result == 8'd0;
		end
	end
endmodule

// ----- design/mos6502_bus_cycle_core.sv -----
// Top level of the 6502 bus-cycle core; uses m6502_pkg and m6502_alu.
// Each transaction on the input channel is the byte that memory returned for the
// previous bus access; each transaction on the output channel is the next access.
//
// The core is a 6502 seen from its memory bus. Every read_data transaction yields
// exactly one result transaction that describes the next access: bus_address,
// bus_write and write_data, plus instruction_done and the opcode's nominal
// instruction_cycles on the opcode fetch that follows a completed instruction.
// Only accesses that carry data are issued. After reset the first input byte is
// ignored; the core then reads the reset vector at FFFC/FFFD and fetches the first
// opcode. BRK pushes PC and P and reads the vector at FFFE. Arithmetic is always
// binary. Throughput is one transaction per clock: the sequencer registers and the
// decode/ALU logic form a single combinational pass, and the result sits in an
// output register that is refilled in the same cycle it is taken, so ready only
// drops while a finished result waits unclaimed downstream.
module mos6502_bus_cycle_core import m6502_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [7:0]              read_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [ADDRESS_BITS-1:0] bus_address,
	output logic                    bus_write,
	output logic [7:0]              write_data,
	output logic                    instruction_done,
	output logic [3:0]              instruction_cycles
);
	// Architectural and sequencing state.
	logic [7:0]  a_q, x_q, y_q, s_q, p_q, opc_q, dt_q;
	logic [15:0] pc_q, at_q;
	step_t       step_q;

	// Next-state values.
	logic [7:0]  a_d, x_d, y_d, s_d, p_d, opc_d, dt_d;
	logic [15:0] pc_d, at_d;
	step_t       step_d;

	// Next access.
	logic [15:0] addr_c;
	logic        wr_c;
	logic [7:0]  wd_c;
	logic        done_c;

	logic        take;
	dec_t        dq, dn, dsel;
	logic [7:0]  alu_val, alu_res, alu_p;
	logic [15:0] ea;
	logic [7:0]  d;
	logic        br_flag;

	assign in_ready = ~out_valid | out_ready;
	assign take = in_valid & in_ready;
	assign d = read_data;

	assign dq = decode(opc_q);
	assign dn = decode(d);
	assign dsel = (step_q == ST_OPCODE) ? dn : dq;

	// The ALU operand is the bus byte, except for accumulator shifts.
	assign alu_val = (step_q == ST_OPCODE) ? a_q : d;

	m6502_alu u_alu (
		.op(dsel.op), .value(alu_val), .acc(a_q), .xr(x_q), .yr(y_q),
		.p_in(p_q), .result(alu_res), .p_out(alu_p)
	);

	always_comb begin
		case (opc_q[7:6])
			2'd0: br_flag = p_q[FL_N];
			2'd1: br_flag = p_q[FL_V];
			2'd2: br_flag = p_q[FL_C];
			default: br_flag = p_q[FL_Z];
		endcase
	end

	always_comb begin
		a_d = a_q; x_d = x_q; y_d = y_q; s_d = s_q; p_d = p_q;
		opc_d = opc_q; dt_d = dt_q; pc_d = pc_q; at_d = at_q; step_d = step_q;
		addr_c = pc_q; wr_c = 1'b0; wd_c = 8'd0; done_c = 1'b0;
		ea = 16'd0;
		unique case (step_q)
			ST_RESET: begin
				at_d = VEC_RESET; addr_c = VEC_RESET; step_d = ST_VEC_LO;
			end
			ST_VEC_LO: begin
				dt_d = d; addr_c = at_q + 16'd1; step_d = ST_VEC_HI;
			end
			ST_VEC_HI: begin
				addr_c = {d, dt_q}; pc_d = {d, dt_q} + 16'd1;
				done_c = at_q == VEC_IRQ; step_d = ST_OPCODE;
			end
			ST_OPCODE: begin
				opc_d = d;
				if (dn.mode != M_IMP) begin
					addr_c = pc_q; pc_d = pc_q + 16'd1; step_d = ST_OPER1;
				end else begin
					case (dn.op)
						O_BRK: begin
							at_d = pc_q + 16'd1;
							addr_c = {STACK_PAGE, s_q}; wr_c = 1'b1; wd_c = at_d[15:8];
							s_d = s_q - 8'd1; step_d = ST_PUSH_HI;
						end
						O_RTS, O_RTI, O_PLA, O_PLP: begin
							s_d = s_q + 8'd1; addr_c = {STACK_PAGE, s_d}; step_d = ST_PULL1;
						end
						O_PHA, O_PHP: begin
							addr_c = {STACK_PAGE, s_q}; wr_c = 1'b1;
							wd_c = (dn.op == O_PHA) ? a_q : (p_q | P_PUSH);
							s_d = s_q - 8'd1; step_d = ST_WDONE;
						end
						default: begin
							case (dn.op)
								O_ASL, O_ROL, O_LSR, O_ROR: begin a_d = alu_res; p_d = alu_p; end
								O_DEY: y_d = y_q - 8'd1;
								O_INY: y_d = y_q + 8'd1;
								O_DEX: x_d = x_q - 8'd1;
								O_INX: x_d = x_q + 8'd1;
								O_TAY: y_d = a_q;
								O_TYA: a_d = y_q;
								O_TAX: x_d = a_q;
								O_TXA: a_d = x_q;
								O_TSX: x_d = s_q;
								O_TXS: s_d = x_q;
								O_CLC: p_d[FL_C] = 1'b0;
								O_SEC: p_d[FL_C] = 1'b1;
								O_CLI: p_d[FL_I] = 1'b0;
								O_SEI: p_d[FL_I] = 1'b1;
								O_CLV: p_d[FL_V] = 1'b0;
								O_CLD: p_d[FL_D] = 1'b0;
								O_SED: p_d[FL_D] = 1'b1;
								default: ;
							endcase
							case (dn.op)
								O_DEY, O_INY: begin p_d[FL_N] = y_d[7]; p_d[FL_Z] = y_d == 8'd0; end
								O_DEX, O_INX, O_TAX, O_TSX: begin
									p_d[FL_N] = x_d[7]; p_d[FL_Z] = x_d == 8'd0;
								end
								O_TAY: begin p_d[FL_N] = y_d[7]; p_d[FL_Z] = y_d == 8'd0; end
								O_TYA, O_TXA: begin p_d[FL_N] = a_d[7]; p_d[FL_Z] = a_d == 8'd0; end
								default: ;
							endcase
							addr_c = pc_q; pc_d = pc_q + 16'd1; done_c = 1'b1; step_d = ST_OPCODE;
						end
					endcase
				end
			end
			ST_OPER1: begin
				// Default outcome: next opcode fetch.
				addr_c = pc_q; pc_d = pc_q + 16'd1; done_c = 1'b1; step_d = ST_OPCODE;
				case (dq.mode)
					M_IMM: ;
					M_ZP: ea = {8'd0, d};
					M_ZPX: ea = {8'd0, d + x_q};
					M_ZPY: ea = {8'd0, d + y_q};
					M_REL: ;
					M_IDX, M_IDY: ;
					default: ;
				endcase
				case (dq.mode)
					M_IMM: begin
						p_d = alu_p;
						case (dq.op)
							O_ORA, O_AND, O_EOR, O_LDA, O_ADC, O_SBC: a_d = alu_res;
							O_LDX: x_d = alu_res;
							O_LDY: y_d = alu_res;
							default: ;
						endcase
						if (dq.op == O_NOP || dq.op == O_STA || dq.op == O_STX ||
							dq.op == O_STY || dq.op == O_JMP) p_d = p_q;
					end
					M_REL: begin
						if (br_flag == opc_q[5]) begin
							addr_c = pc_q + {{8{d[7]}}, d};
							pc_d = addr_c + 16'd1;
						end
					end
					M_IDX, M_IDY: begin
						at_d = (dq.mode == M_IDX) ? {8'd0, d + x_q} : {8'd0, d};
						addr_c = at_d; pc_d = pc_q; done_c = 1'b0; step_d = ST_PTR_LO;
					end
					M_ABS, M_ABX, M_ABY, M_IND: begin
						dt_d = d; addr_c = pc_q; pc_d = pc_q + 16'd1;
						done_c = 1'b0; step_d = ST_OPER2;
					end
					M_ZP, M_ZPX, M_ZPY: begin
						pc_d = pc_q; done_c = 1'b0;
					end
					default: ;
				endcase
			end
			ST_OPER2: begin
				if (dq.op == O_JMP && dq.mode == M_ABS) begin
					addr_c = {d, dt_q}; pc_d = {d, dt_q} + 16'd1;
					done_c = 1'b1; step_d = ST_OPCODE;
				end else if (dq.op == O_JSR) begin
					at_d = pc_q - 16'd1; pc_d = {d, dt_q};
					addr_c = {STACK_PAGE, s_q}; wr_c = 1'b1; wd_c = at_d[15:8];
					s_d = s_q - 8'd1; step_d = ST_PUSH_HI;
				end else if (dq.mode == M_IND) begin
					at_d = {d, dt_q}; addr_c = at_d; step_d = ST_PTR_LO;
				end else if (dq.mode == M_ABX) begin
					ea = {d, dt_q} + {8'd0, x_q};
				end else if (dq.mode == M_ABY) begin
					ea = {d, dt_q} + {8'd0, y_q};
				end else begin
					ea = {d, dt_q};
				end
			end
			ST_PTR_LO: begin
				dt_d = d; addr_c = {at_q[15:8], at_q[7:0] + 8'd1}; step_d = ST_PTR_HI;
			end
			ST_PTR_HI: begin
				if (dq.mode == M_IND) begin
					addr_c = {d, dt_q}; pc_d = {d, dt_q} + 16'd1;
					done_c = 1'b1; step_d = ST_OPCODE;
				end else begin
					ea = (dq.mode == M_IDY) ? ({d, dt_q} + {8'd0, y_q}) : {d, dt_q};
				end
			end
			ST_DATA: begin
				if (dq.op == O_ASL || dq.op == O_ROL || dq.op == O_LSR || dq.op == O_ROR ||
					dq.op == O_INC || dq.op == O_DEC) begin
					p_d = alu_p; addr_c = at_q; wr_c = 1'b1; wd_c = alu_res; step_d = ST_WDONE;
				end else begin
					case (dq.op)
						O_ORA, O_AND, O_EOR, O_LDA, O_ADC, O_SBC: begin a_d = alu_res; p_d = alu_p; end
						O_LDX: begin x_d = alu_res; p_d = alu_p; end
						O_LDY: begin y_d = alu_res; p_d = alu_p; end
						O_CMP, O_CPX, O_CPY, O_BIT: p_d = alu_p;
						default: ;
					endcase
					addr_c = pc_q; pc_d = pc_q + 16'd1; done_c = 1'b1; step_d = ST_OPCODE;
				end
			end
			ST_PUSH_HI: begin
				addr_c = {STACK_PAGE, s_q}; wr_c = 1'b1; wd_c = at_q[7:0];
				s_d = s_q - 8'd1; step_d = ST_PUSH_LO;
			end
			ST_PUSH_LO: begin
				if (dq.op == O_BRK) begin
					addr_c = {STACK_PAGE, s_q}; wr_c = 1'b1; wd_c = p_q | P_PUSH;
					s_d = s_q - 8'd1; step_d = ST_PUSH_P;
				end else begin
					addr_c = pc_q; pc_d = pc_q + 16'd1; done_c = 1'b1; step_d = ST_OPCODE;
				end
			end
			ST_PUSH_P: begin
				p_d[FL_I] = 1'b1; at_d = VEC_IRQ; addr_c = VEC_IRQ; step_d = ST_VEC_LO;
			end
			ST_PULL1: begin
				addr_c = pc_q; pc_d = pc_q + 16'd1; done_c = 1'b1; step_d = ST_OPCODE;
				if (dq.op == O_PLA) begin
					a_d = d; p_d[FL_N] = d[7]; p_d[FL_Z] = d == 8'd0;
				end else if (dq.op == O_PLP) begin
					p_d = (d & P_PULL) | P_RESET;
				end else if (dq.op == O_RTI || dq.op == O_RTS) begin
					if (dq.op == O_RTI) p_d = (d & P_PULL) | P_RESET;
					else dt_d = d;
					pc_d = pc_q; done_c = 1'b0;
					s_d = s_q + 8'd1; addr_c = {STACK_PAGE, s_d}; step_d = ST_PULL2;
				end
			end
			ST_PULL2: begin
				if (dq.op == O_RTI) begin
					dt_d = d; s_d = s_q + 8'd1; addr_c = {STACK_PAGE, s_d}; step_d = ST_PULL3;
				end else begin
					addr_c = (dq.op == O_RTS) ? ({d, dt_q} + 16'd1) : pc_q;
					pc_d = addr_c + 16'd1; done_c = 1'b1; step_d = ST_OPCODE;
				end
			end
			ST_PULL3: begin
				addr_c = {d, dt_q}; pc_d = {d, dt_q} + 16'd1; done_c = 1'b1; step_d = ST_OPCODE;
			end
			default: begin
				// Write completed: fetch the next opcode.
				addr_c = pc_q; pc_d = pc_q + 16'd1; done_c = 1'b1; step_d = ST_OPCODE;
			end
		endcase
		// Effective-address dispatch shared by operand and pointer steps.
		if ((step_q == ST_OPER1 && (dq.mode == M_ZP || dq.mode == M_ZPX || dq.mode == M_ZPY)) ||
			(step_q == ST_OPER2 && !(dq.op == O_JMP && dq.mode == M_ABS) && dq.op != O_JSR &&
			 dq.mode != M_IND) ||
			(step_q == ST_PTR_HI && dq.mode != M_IND)) begin
			at_d = ea; addr_c = ea; done_c = 1'b0;
			if (dq.op == O_STA || dq.op == O_STX || dq.op == O_STY) begin
				wr_c = 1'b1;
				wd_c = (dq.op == O_STA) ? a_q : (dq.op == O_STX) ? x_q : y_q;
				step_d = ST_WDONE;
			end else begin
				step_d = ST_DATA;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= 8'd0; x_q <= 8'd0; y_q <= 8'd0; s_q <= SP_RESET; p_q <= P_RESET;
			pc_q <= 16'd0; at_q <= 16'd0; opc_q <= 8'd0; dt_q <= 8'd0;
			step_q <= ST_RESET; out_valid <= 1'b0;
		end else begin
			if (take) begin
				a_q <= a_d; x_q <= x_d; y_q <= y_d; s_q <= s_d; p_q <= p_d;
				pc_q <= pc_d; at_q <= at_d; opc_q <= opc_d; dt_q <= dt_d; step_q <= step_d;
			end
			if (take) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			bus_address <= addr_c[ADDRESS_BITS-1:0];
			bus_write <= wr_c;
			write_data <= wr_c ? wd_c : 8'd0;
			instruction_done <= done_c;
			instruction_cycles <= done_c ? cyc_lookup(opc_d) : 4'd0;
		end
	end

	// A finished result is never overwritten before it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready) else $error("result overwritten");
	// Bit 5 of P is constant and bit 4 never stored.
	a_pflags: assert property (@(posedge clk) disable iff (!arst_n)
		p_q[5] && !p_q[4]) else $error("P reserved bits wrong");
	// Cycle count is reported only with instruction_done.
	a_cyc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !instruction_done |-> instruction_cycles == 4'd0)
		else $error("cycles without done");
	// Writes never mark instruction completion.
	a_wr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bus_write |-> !instruction_done) else $error("done on write");
endmodule

// ----- tb/sv/mos6502_bus_cycle_core_tb.sv -----
// Self-checking testbench for mos6502_bus_cycle_core: a directed stimulus table and
// random bus replies, each result checked against a typed access or a local bus-cycle predictor.
// Depends on m6502_pkg and the core itself.
module mos6502_bus_cycle_core_tb import m6502_pkg::*;;

	// One bus access as the core reports it on the result channel.
	typedef struct packed {
		logic [ADDRESS_BITS-1:0] addr;
		logic                    wr;
		logic [7:0]              wdata;
		logic                    done;
		logic [3:0]              cycles;
	} access_t;

	// A directed row: the reply byte, and where it is obvious, the access it must cause.
	typedef struct packed {
		logic [7:0] reply;
		logic       typed;
		access_t    want;
	} dir_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [7:0]              read_data;
	logic                    out_valid;
	logic                    out_ready;
	logic [ADDRESS_BITS-1:0] bus_address;
	logic                    bus_write;
	logic [7:0]              write_data;
	logic                    instruction_done;
	logic [3:0]              instruction_cycles;

	// Architectural state of the modeled processor, kept by the predictor.
	logic [7:0]  acc, xr, yr, sp, pf;
	logic [15:0] pc, atmp;
	logic [7:0]  opc, dtmp;
	step_t       stp;
	access_t     nxt_access;

	access_t pending_accesses [$];
	int      errors;
	bit      quiet;
	bit      stim_done;

	// Nominal cycle counts per opcode, row by row of 32 opcodes.
	int cyc_tab [0:255] = '{
		7,6,0,8,3,3,5,5,3,2,2,2,4,4,6,6, 2,5,0,8,4,4,6,6,2,4,2,7,4,4,7,7,
		6,6,0,8,3,3,5,5,4,2,2,2,4,4,6,6, 2,5,0,8,4,4,6,6,2,4,2,7,4,4,7,7,
		6,6,0,8,3,3,5,5,3,2,2,2,3,4,6,6, 2,5,0,8,4,4,6,6,2,4,2,7,4,4,7,7,
		6,6,0,8,3,3,5,5,4,2,2,2,5,4,6,6, 2,5,0,8,4,4,6,6,2,4,2,7,4,4,7,7,
		1,6,2,6,3,3,3,3,2,2,2,2,4,4,4,4, 2,6,0,6,4,4,4,4,2,5,2,5,5,5,5,5,
		2,6,2,6,3,3,3,3,2,2,2,2,4,4,4,4, 2,5,0,5,4,4,4,4,2,4,2,4,4,4,4,4,
		2,6,2,8,3,3,5,5,2,2,2,2,4,4,6,6, 2,5,0,8,4,4,6,6,2,4,2,7,4,4,7,7,
		2,6,2,8,3,3,5,5,2,2,2,2,4,4,6,6, 2,5,0,8,4,4,6,6,2,4,2,7,4,4,7,7
	};

	mos6502_bus_cycle_core u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.read_data         (read_data),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.bus_address       (bus_address),
		.bus_write         (bus_write),
		.write_data        (write_data),
		.instruction_done  (instruction_done),
		.instruction_cycles(instruction_cycles)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Opcode classification. The opcode splits into aaa/bbb/cc fields; cc=1 is the
	// ALU group, cc=2 the shift/load-store-X group, cc=0 the control group. Anything
	// not recognized falls through as a one-byte no-op.
	function automatic op_t classify(input logic [7:0] o, output mode_t m);
		op_t r;
		logic [2:0] aaa;
		logic [2:0] bbb;
		aaa = o[7:5];
		bbb = o[4:2];
		r = O_NOP;
		m = M_IMP;
		if (o[1:0] == 2'd1) begin
			if (o != 8'h89) begin
				case (aaa)
					3'd0: r = O_ORA;
					3'd1: r = O_AND;
					3'd2: r = O_EOR;
					3'd3: r = O_ADC;
					3'd4: r = O_STA;
					3'd5: r = O_LDA;
					3'd6: r = O_CMP;
					default: r = O_SBC;
				endcase
				case (bbb)
					3'd0: m = M_IDX;
					3'd1: m = M_ZP;
					3'd2: m = M_IMM;
					3'd3: m = M_ABS;
					3'd4: m = M_IDY;
					3'd5: m = M_ZPX;
					3'd6: m = M_ABY;
					default: m = M_ABX;
				endcase
			end
		end else if (o[1:0] == 2'd2) begin
			case (aaa)
				3'd0: r = O_ASL;
				3'd1: r = O_ROL;
				3'd2: r = O_LSR;
				3'd3: r = O_ROR;
				3'd4: r = O_STX;
				3'd5: r = O_LDX;
				3'd6: r = O_DEC;
				default: r = O_INC;
			endcase
			case (bbb)
				3'd0: if (o == 8'hA2) m = M_IMM; else r = O_NOP;
				3'd1: m = M_ZP;
				3'd2: begin
					// Accumulator shifts keep their op; the high half holds transfers.
					if (aaa >= 3'd4) begin
						if (o == 8'h8A) r = O_TXA;
						else if (o == 8'hAA) r = O_TAX;
						else if (o == 8'hCA) r = O_DEX;
						else r = O_NOP;
					end
				end
				3'd3: m = M_ABS;
				3'd5: m = (aaa == 3'd4 || aaa == 3'd5) ? M_ZPY : M_ZPX;
				3'd6: begin
					if (o == 8'h9A) r = O_TXS;
					else if (o == 8'hBA) r = O_TSX;
					else r = O_NOP;
				end
				3'd7: if (aaa == 3'd4) r = O_NOP; else m = (aaa == 3'd5) ? M_ABY : M_ABX;
				default: r = O_NOP;
			endcase
		end else if (o[1:0] == 2'd0) begin
			if (o[4:0] == 5'h10) begin
				r = O_BR;
				m = M_REL;
			end else if (o[3:0] == 4'h8) begin
				case (o[7:4])
					4'h0: r = O_PHP;
					4'h1: r = O_CLC;
					4'h2: r = O_PLP;
					4'h3: r = O_SEC;
					4'h4: r = O_PHA;
					4'h5: r = O_CLI;
					4'h6: r = O_PLA;
					4'h7: r = O_SEI;
					4'h8: r = O_DEY;
					4'h9: r = O_TYA;
					4'hA: r = O_TAY;
					4'hB: r = O_CLV;
					4'hC: r = O_INY;
					4'hD: r = O_CLD;
					4'hE: r = O_INX;
					default: r = O_SED;
				endcase
			end else begin
				case (o)
					8'h00: r = O_BRK;
					8'h20: begin r = O_JSR; m = M_ABS; end
					8'h40: r = O_RTI;
					8'h60: r = O_RTS;
					8'h24: begin r = O_BIT; m = M_ZP; end
					8'h2C: begin r = O_BIT; m = M_ABS; end
					8'h4C: begin r = O_JMP; m = M_ABS; end
					8'h6C: begin r = O_JMP; m = M_IND; end
					8'h84: begin r = O_STY; m = M_ZP; end
					8'h8C: begin r = O_STY; m = M_ABS; end
					8'h94: begin r = O_STY; m = M_ZPX; end
					8'hA0: begin r = O_LDY; m = M_IMM; end
					8'hA4: begin r = O_LDY; m = M_ZP; end
					8'hAC: begin r = O_LDY; m = M_ABS; end
					8'hB4: begin r = O_LDY; m = M_ZPX; end
					8'hBC: begin r = O_LDY; m = M_ABX; end
					8'hC0: begin r = O_CPY; m = M_IMM; end
					8'hC4: begin r = O_CPY; m = M_ZP; end
					8'hCC: begin r = O_CPY; m = M_ABS; end
					8'hE0: begin r = O_CPX; m = M_IMM; end
					8'hE4: begin r = O_CPX; m = M_ZP; end
					8'hEC: begin r = O_CPX; m = M_ABS; end
					default: r = O_NOP;
				endcase
			end
		end
		return r;
	endfunction

	task automatic set_nz(input logic [7:0] v);
		pf[FL_N] = v[7];
		pf[FL_Z] = (v == 8'h00);
	endtask

	task automatic issue(input logic [15:0] a, input logic w, input logic [7:0] dat,
			input logic dn);
		nxt_access.addr   = a[ADDRESS_BITS-1:0];
		nxt_access.wr     = w;
		nxt_access.wdata  = w ? dat : 8'h00;
		nxt_access.done   = dn;
		nxt_access.cycles = dn ? 4'(cyc_tab[opc]) : 4'd0;
	endtask

	task automatic read_from(input logic [15:0] a, input step_t nx);
		issue(a, 1'b0, 8'h00, 1'b0);
		stp = nx;
	endtask

	task automatic fetch_next(input logic dn);
		issue(pc, 1'b0, 8'h00, dn);
		pc  = pc + 16'd1;
		stp = ST_OPCODE;
	endtask

	task automatic read_operand(input step_t nx);
		read_from(pc, nx);
		pc = pc + 16'd1;
	endtask

	task automatic stack_push(input logic [7:0] dat, input step_t nx);
		issue({STACK_PAGE, sp}, 1'b1, dat, 1'b0);
		sp  = sp - 8'd1;
		stp = nx;
	endtask

	task automatic stack_pull(input step_t nx);
		sp = sp + 8'd1;
		read_from({STACK_PAGE, sp}, nx);
	endtask

	// Binary add with carry in; SBC arrives here with the operand inverted.
	task automatic add_with_carry(input logic [7:0] v);
		logic [8:0] s;
		s = {1'b0, acc} + {1'b0, v} + {8'd0, pf[FL_C]};
		pf[FL_C] = s[8];
		pf[FL_V] = ~(acc[7] ^ v[7]) & (acc[7] ^ s[7]);
		acc = s[7:0];
		set_nz(acc);
	endtask

	task automatic compare_to(input logic [7:0] r, input logic [7:0] v);
		pf[FL_C] = (r >= v);
		set_nz(r - v);
	endtask

	task automatic apply_operand(input op_t op, input logic [7:0] v);
		case (op)
			O_ORA: begin acc = acc | v; set_nz(acc); end
			O_AND: begin acc = acc & v; set_nz(acc); end
			O_EOR: begin acc = acc ^ v; set_nz(acc); end
			O_LDA: begin acc = v; set_nz(v); end
			O_LDX: begin xr = v; set_nz(v); end
			O_LDY: begin yr = v; set_nz(v); end
			O_ADC: add_with_carry(v);
			O_SBC: add_with_carry(~v);
			O_CMP: compare_to(acc, v);
			O_CPX: compare_to(xr, v);
			O_CPY: compare_to(yr, v);
			O_BIT: begin
				pf[FL_N] = v[7];
				pf[FL_V] = v[6];
				pf[FL_Z] = ((v & acc) == 8'h00);
			end
			default: ;
		endcase
	endtask

	// Shift, rotate, increment and decrement; rotates go through carry.
	function automatic logic [7:0] shift_or_step(input op_t op, input logic [7:0] v);
		logic [7:0] r;
		logic c;
		c = pf[FL_C];
		r = v;
		case (op)
			O_ASL: begin pf[FL_C] = v[7]; r = {v[6:0], 1'b0}; end
			O_ROL: begin pf[FL_C] = v[7]; r = {v[6:0], c}; end
			O_LSR: begin pf[FL_C] = v[0]; r = {1'b0, v[7:1]}; end
			O_ROR: begin pf[FL_C] = v[0]; r = {c, v[7:1]}; end
			O_INC: r = v + 8'd1;
			O_DEC: r = v - 8'd1;
			default: ;
		endcase
		pf[FL_N] = r[7];
		pf[FL_Z] = (r == 8'h00);
		return r;
	endfunction

	task automatic run_implied(input op_t op);
		case (op)
			O_ASL, O_ROL, O_LSR, O_ROR: acc = shift_or_step(op, acc);
			O_DEY: begin yr = yr - 8'd1; set_nz(yr); end
			O_INY: begin yr = yr + 8'd1; set_nz(yr); end
			O_DEX: begin xr = xr - 8'd1; set_nz(xr); end
			O_INX: begin xr = xr + 8'd1; set_nz(xr); end
			O_TAY: begin yr = acc; set_nz(yr); end
			O_TYA: begin acc = yr; set_nz(acc); end
			O_TAX: begin xr = acc; set_nz(xr); end
			O_TXA: begin acc = xr; set_nz(acc); end
			O_TSX: begin xr = sp; set_nz(xr); end
			O_TXS: sp = xr;
			O_CLC: pf[FL_C] = 1'b0;
			O_SEC: pf[FL_C] = 1'b1;
			O_CLI: pf[FL_I] = 1'b0;
			O_SEI: pf[FL_I] = 1'b1;
			O_CLV: pf[FL_V] = 1'b0;
			O_CLD: pf[FL_D] = 1'b0;
			O_SED: pf[FL_D] = 1'b1;
			default: ;
		endcase
	endtask

	// Stores write straight away; everything else reads the operand first.
	task automatic effective_address(input op_t op, input logic [15:0] a);
		atmp = a;
		if (op == O_STA || op == O_STX || op == O_STY) begin
			issue(atmp, 1'b1, (op == O_STA) ? acc : (op == O_STX) ? xr : yr, 1'b0);
			stp = ST_WDONE;
		end else begin
			read_from(atmp, ST_DATA);
		end
	endtask

	task automatic reset_cpu_state();
		acc  = 8'h00;
		xr   = 8'h00;
		yr   = 8'h00;
		sp   = SP_RESET;
		pf   = P_RESET;
		pc   = 16'h0000;
		opc  = 8'h00;
		stp  = ST_RESET;
		atmp = 16'h0000;
		dtmp = 8'h00;
	endtask

	// Advances the predicted core by one bus reply and leaves the next access in
	// nxt_access.
	task automatic predict_bus_cycle(input logic [7:0] d);
		op_t        op;
		mode_t      md;
		logic [15:0] a;
		logic       taken;
		op = classify(opc, md);
		a  = {d, dtmp};
		case (stp)
			ST_RESET: begin
				atmp = VEC_RESET;
				read_from(atmp, ST_VEC_LO);
			end
			ST_VEC_LO: begin
				dtmp = d;
				read_from(atmp + 16'd1, ST_VEC_HI);
			end
			ST_VEC_HI: begin
				pc = a;
				// Only the vector fetch that ends a BRK completes an instruction.
				fetch_next(atmp == VEC_IRQ);
			end
			ST_OPCODE: begin
				opc = d;
				op  = classify(d, md);
				if (md != M_IMP) begin
					read_operand(ST_OPER1);
				end else begin
					case (op)
						O_BRK: begin
							atmp = pc + 16'd1;
							stack_push(atmp[15:8], ST_PUSH_HI);
						end
						O_RTS, O_RTI, O_PLA, O_PLP: stack_pull(ST_PULL1);
						O_PHA: stack_push(acc, ST_WDONE);
						O_PHP: stack_push(pf | P_PUSH, ST_WDONE);
						default: begin
							run_implied(op);
							fetch_next(1'b1);
						end
					endcase
				end
			end
			ST_OPER1: begin
				case (md)
					M_IMM: begin
						apply_operand(op, d);
						fetch_next(1'b1);
					end
					M_ZP:  effective_address(op, {8'h00, d});
					M_ZPX: effective_address(op, {8'h00, d + xr});
					M_ZPY: effective_address(op, {8'h00, d + yr});
					M_REL: begin
						case (opc[7:6])
							2'd0: taken = pf[FL_N];
							2'd1: taken = pf[FL_V];
							2'd2: taken = pf[FL_C];
							default: taken = pf[FL_Z];
						endcase
						if (taken == opc[5]) pc = pc + {{8{d[7]}}, d};
						fetch_next(1'b1);
					end
					M_IDX: begin
						atmp = {8'h00, d + xr};
						read_from(atmp, ST_PTR_LO);
					end
					M_IDY: begin
						atmp = {8'h00, d};
						read_from(atmp, ST_PTR_LO);
					end
					M_ABS, M_ABX, M_ABY, M_IND: begin
						dtmp = d;
						read_operand(ST_OPER2);
					end
					default: fetch_next(1'b1);
				endcase
			end
			ST_OPER2: begin
				if (op == O_JMP && md == M_ABS) begin
					pc = a;
					fetch_next(1'b1);
				end else if (op == O_JSR) begin
					atmp = pc - 16'd1;
					pc   = a;
					stack_push(atmp[15:8], ST_PUSH_HI);
				end else if (md == M_IND) begin
					atmp = a;
					read_from(a, ST_PTR_LO);
				end else if (md == M_ABX) begin
					effective_address(op, a + {8'h00, xr});
				end else if (md == M_ABY) begin
					effective_address(op, a + {8'h00, yr});
				end else begin
					effective_address(op, a);
				end
			end
			ST_PTR_LO: begin
				// The pointer's second byte stays within the same page.
				dtmp = d;
				read_from({atmp[15:8], atmp[7:0] + 8'd1}, ST_PTR_HI);
			end
			ST_PTR_HI: begin
				if (md == M_IND) begin
					pc = a;
					fetch_next(1'b1);
				end else begin
					effective_address(op, (md == M_IDY) ? a + {8'h00, yr} : a);
				end
			end
			ST_DATA: begin
				if (op == O_ASL || op == O_ROL || op == O_LSR || op == O_ROR ||
						op == O_INC || op == O_DEC) begin
					issue(atmp, 1'b1, shift_or_step(op, d), 1'b0);
					stp = ST_WDONE;
				end else begin
					apply_operand(op, d);
					fetch_next(1'b1);
				end
			end
			ST_PUSH_HI: stack_push(atmp[7:0], ST_PUSH_LO);
			ST_PUSH_LO: begin
				if (op == O_BRK) stack_push(pf | P_PUSH, ST_PUSH_P);
				else fetch_next(1'b1);
			end
			ST_PUSH_P: begin
				pf[FL_I] = 1'b1;
				atmp = VEC_IRQ;
				read_from(atmp, ST_VEC_LO);
			end
			ST_PULL1: begin
				if (op == O_PLA) begin
					acc = d;
					set_nz(d);
					fetch_next(1'b1);
				end else if (op == O_PLP) begin
					pf = (d & P_PULL) | P_RESET;
					fetch_next(1'b1);
				end else if (op == O_RTI) begin
					pf = (d & P_PULL) | P_RESET;
					stack_pull(ST_PULL2);
				end else if (op == O_RTS) begin
					dtmp = d;
					stack_pull(ST_PULL2);
				end else begin
					fetch_next(1'b1);
				end
			end
			ST_PULL2: begin
				if (op == O_RTI) begin
					dtmp = d;
					stack_pull(ST_PULL3);
				end else begin
					if (op == O_RTS) pc = a + 16'd1;
					fetch_next(1'b1);
				end
			end
			ST_PULL3: begin
				pc = a;
				fetch_next(1'b1);
			end
			default: fetch_next(1'b1);
		endcase
	endtask

	// Sends one reply byte. A random gap of idle cycles precedes it unless the run is
	// in a quiet stretch; valid stays high across back-to-back transactions.
	task automatic send_reply(input logic [7:0] d, input logic typed, input access_t want);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		read_data <= d;
		do @(posedge clk); while (!in_ready);
		predict_bus_cycle(d);
		pending_accesses.push_back(typed ? want : nxt_access);
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// Result side: draws a stall per transaction, then compares field by field with
	// the oldest expected access.
	initial begin
		int      stall;
		access_t want;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (pending_accesses.size() == 0) begin
				$display("%0t: unexpected access, got address %0h", $time, bus_address);
				errors++;
			end else begin
				want = pending_accesses.pop_front();
				check_field("bus_address", want.addr, bus_address);
				check_field("bus_write", want.wr, bus_write);
				check_field("write_data", want.wdata, write_data);
				check_field("instruction_done", want.done, instruction_done);
				check_field("instruction_cycles", want.cycles, instruction_cycles);
			end
		end
	end

	// Directed replies. The first few are typed in from the reset sequence and
	// simple arithmetic; the rest walk BRK, RTI, JSR, RTS, indirect JMP across a
	// page end, an undocumented opcode, rotate through carry and a compare whose
	// difference is negative, and are checked against the predictor.
	localparam int N_DIR = 33;
	dir_row_t dir_rows [N_DIR] = '{
		'{8'h5A, 1'b1, '{16'hFFFC, 1'b0, 8'h00, 1'b0, 4'd0}}, // ignored after reset
		'{8'h34, 1'b1, '{16'hFFFD, 1'b0, 8'h00, 1'b0, 4'd0}},
		'{8'h12, 1'b1, '{16'h1234, 1'b0, 8'h00, 1'b0, 4'd0}},
		'{8'hA9, 1'b1, '{16'h1235, 1'b0, 8'h00, 1'b0, 4'd0}}, // LDA #
		'{8'h80, 1'b1, '{16'h1236, 1'b0, 8'h00, 1'b1, 4'd2}},
		'{8'h00, 1'b1, '{16'h01FF, 1'b1, 8'h12, 1'b0, 4'd0}}, // BRK pushes PC high
		'{8'hFF, 1'b0, '0},                                   // ignored after write
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},                                   // vector low
		'{8'h20, 1'b0, '0},                                   // vector high
		'{8'h40, 1'b0, '0},                                   // RTI
		'{8'hFF, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h30, 1'b0, '0},
		'{8'h20, 1'b0, '0},                                   // JSR 4010
		'{8'h10, 1'b0, '0},
		'{8'h40, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h60, 1'b0, '0},                                   // RTS
		'{8'h02, 1'b0, '0},
		'{8'h30, 1'b0, '0},
		'{8'h6C, 1'b0, '0},                                   // JMP (50FF)
		'{8'hFF, 1'b0, '0},
		'{8'h50, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h60, 1'b0, '0},
		'{8'h02, 1'b0, '0},                                   // undocumented no-op
		'{8'h2A, 1'b0, '0},                                   // ROL A
		'{8'hC9, 1'b0, '0},                                   // CMP #
		'{8'hFF, 1'b0, '0},
		'{8'hE9, 1'b0, '0}                                    // SBC #, random operand next
	};

	// Stack and control flow opcodes are favored so that random code keeps moving
	// through the push, pull and vector sequences.
	logic [7:0] flow_ops [10] = '{8'h00, 8'h20, 8'h40, 8'h60, 8'h6C, 8'h08, 8'h28,
		8'h48, 8'h68, 8'h4C};

	initial begin
		logic [7:0] b;
		errors    = 0;
		quiet     = 1'b0;
		stim_done = 1'b0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		read_data = 8'h00;
		reset_cpu_state();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++) begin
			send_reply(dir_rows[i].reply, dir_rows[i].typed, dir_rows[i].want);
		end

		for (int i = 0; i < 900; i++) begin
			// Alternate stretches with and without idle cycles on both sides.
			if (i % 150 == 0) quiet = ~quiet;
			if (i == 450) begin
				in_valid <= 1'b0;
				while (pending_accesses.size() != 0) @(posedge clk);
			end
			b = ($urandom_range(0, 7) == 0) ? flow_ops[$urandom_range(0, 9)]
				: 8'($urandom_range(0, 255));
			send_reply(b, 1'b0, '0);
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	initial begin
		@(posedge stim_done);
		while (pending_accesses.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("mos6502_bus_cycle_core: match");
		end else begin
			$display("mos6502_bus_cycle_core: mismatch");
		end
		$finish;
	end

	initial begin
		#(12 * 200000);
		$display("mos6502_bus_cycle_core: mismatch");
		$finish;
	end

endmodule

// ----- mos6502_bus_cycle_core.f -----
design/m6502_pkg.sv
design/m6502_alu.sv
design/mos6502_bus_cycle_core.sv
tb/sv/mos6502_bus_cycle_core_tb.sv
